/* rtl/assert_macros.svh */
// Assertion helpers for the top-level RTL; clock and reset are taken from the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lrts_pkg.sv */
package lrts_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int TIME_BITS = 16;
    localparam int SLOT_BITS = $clog2(NUM_SLOTS);
    localparam int CNT_BITS  = $clog2(NUM_SLOTS + 1);

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // Request kinds carried on s_tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [SLOT_BITS-1:0] slot_t;

    // Input request payload, last field in the lowest bits
    typedef struct packed {
        logic [4:0] pad;
        logic [15:0] burst;
        logic [15:0] arrival;
        logic [2:0]  slot;
    } in_item_t;

    // Result payload, last field in the lowest bits
    typedef struct packed {
        logic [1:0]  pad;
        logic        all_done;
        logic [15:0] waiting;
        logic [15:0] turnaround;
        logic [15:0] finish_time;
        logic        finished;
        logic [2:0]  running_slot;
        logic        idle;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_clr;
        logic scan_step;
        logic update;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_full;
    } dp_stat_t;

endpackage

/* rtl/longest_remaining_time_scheduler.sv */
// Longest-remaining-time-first scheduler over eight job slots. A load request (s_tuser low)
// writes one slot's arrival time and burst and returns nothing. A tick request (s_tuser high)
// presents one result: the controller walks all eight slots through one shared comparator,
// one slot per cycle, then does the write-back and time step in the update state and loads
// the output register in the emit state. The next request is taken as soon as the result is
// registered; the emit state waits only while m_tready is low and an earlier result still
// sits in the output register.
module longest_remaining_time_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // slot[2:0], arrival[18:3], burst[34:19], zero pad
    input  logic        s_tuser,   // cmd: 0 load, 1 tick
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // idle, running_slot, finished, finish_time,
                                   // turnaround, waiting, all_done, zero pad
);
    import lrts_pkg::*;

    `include "assert_macros.svh"

    dp_cmd_t   cmd;
    dp_stat_t  stat;
    in_item_t  in_item;
    out_item_t out_item;

    assign in_item = in_item_t'(s_tdata);
    assign m_tdata = 56'(out_item);

    lrts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lrts_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_item  (in_item),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .out_item (out_item)
    );

    `ASSERT_NEXT(a_tick_blocks_input, s_tvalid && s_tready && (s_tuser == CMD_TICK), !s_tready, "request taken during a tick")
    `ASSERT_IMPLIES(a_emit_needs_room, cmd.emit, !stat.out_full, "result overwrites pending result")
    `ASSERT_IMPLIES(a_idle_not_finished, m_tvalid, !(out_item.idle && out_item.finished), "idle tick reports a finish")

endmodule

/* rtl/lrts_ctrl.sv */
module lrts_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tuser,
    output logic               s_tready,
    input  lrts_pkg::dp_stat_t stat,
    output lrts_pkg::dp_cmd_t  cmd
);
    import lrts_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = s_tvalid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser == CMD_TICK))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!stat.out_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready     = 1'b1;
                cmd.load     = accept && (s_tuser == CMD_LOAD);
                cmd.scan_clr = accept && (s_tuser == CMD_TICK);
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            ST_EMIT:
            begin
                // hold the result until the output register frees up
                cmd.emit = !stat.out_full;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/lrts_dp.sv */
module lrts_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  lrts_pkg::dp_cmd_t  cmd,
    output lrts_pkg::dp_stat_t stat,
    input  lrts_pkg::in_item_t in_item,
    input  logic               m_tready,
    output logic               m_tvalid,
    output lrts_pkg::out_item_t out_item
);
    import lrts_pkg::*;

    time_t arrival_mem [NUM_SLOTS];
    time_t burst_mem   [NUM_SLOTS];
    time_t remain_reg  [NUM_SLOTS];

    time_t                cur_time_reg;
    slot_t                idx_reg;
    logic                 found_reg;
    slot_t                best_idx_reg;
    time_t                best_rem_reg;
    time_t                best_arr_reg;
    time_t                best_burst_reg;
    logic [CNT_BITS-1:0]  nz_cnt_reg;
    logic                 fin_reg;
    logic                 done_reg;
    time_t                turn_reg;
    logic                 out_valid_reg;
    out_item_t            out_reg;

    time_t     rd_rem;
    time_t     rd_arr;
    time_t     rd_burst;
    logic      eligible;
    logic      better;
    time_t     time_next;
    time_t     wait_val;
    out_item_t out_next;

    assign rd_rem   = remain_reg[idx_reg];
    assign rd_arr   = arrival_mem[idx_reg];
    assign rd_burst = burst_mem[idx_reg];

    assign eligible = (rd_rem != '0) && (rd_arr <= cur_time_reg);
    assign better   = !found_reg || (rd_rem > best_rem_reg) ||
                      ((rd_rem == best_rem_reg) && (rd_arr < best_arr_reg));

    assign time_next = (cur_time_reg == TIME_MAX) ? cur_time_reg
                                                  : cur_time_reg + time_t'(1);

    // waiting drops to zero where saturation shortened the turnaround
    assign wait_val = (turn_reg >= best_burst_reg) ? turn_reg - best_burst_reg : '0;

    always_comb
    begin
        out_next              = '0;
        out_next.idle         = !found_reg;
        out_next.running_slot = found_reg ? 3'(best_idx_reg) : 3'd0;
        out_next.finished     = fin_reg;
        out_next.finish_time  = 16'(cur_time_reg);
        out_next.turnaround   = fin_reg ? 16'(turn_reg) : 16'd0;
        out_next.waiting      = fin_reg ? 16'(wait_val) : 16'd0;
        out_next.all_done     = done_reg;
    end

    assign stat.scan_last = (idx_reg == slot_t'(NUM_SLOTS - 1));
    assign stat.out_full  = out_valid_reg && !m_tready;
    assign m_tvalid       = out_valid_reg;
    assign out_item       = out_reg;

    // slot tables without reset: only read for slots that hold work
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            arrival_mem[slot_t'(in_item.slot)] <= time_t'(in_item.arrival);
            burst_mem[slot_t'(in_item.slot)]   <= time_t'(in_item.burst);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                remain_reg[i] <= '0;
            end
            cur_time_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                remain_reg[slot_t'(in_item.slot)] <= time_t'(in_item.burst);
            end
            else if (cmd.update && found_reg)
            begin
                remain_reg[best_idx_reg] <= best_rem_reg - time_t'(1);
            end
            if (cmd.update)
            begin
                cur_time_reg <= time_next;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            found_reg  <= 1'b0;
            nz_cnt_reg <= '0;
            fin_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.scan_clr)
            begin
                idx_reg    <= '0;
                found_reg  <= 1'b0;
                nz_cnt_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + slot_t'(1);
                if (rd_rem != '0)
                begin
                    nz_cnt_reg <= nz_cnt_reg + CNT_BITS'(1);
                end
                if (eligible && better)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.update)
            begin
                fin_reg  <= found_reg && (best_rem_reg == time_t'(1));
                // the picked slot is the only one left with work when the count is one
                done_reg <= (nz_cnt_reg == '0) ||
                            ((nz_cnt_reg == CNT_BITS'(1)) && found_reg &&
                             (best_rem_reg == time_t'(1)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && eligible && better)
        begin
            best_idx_reg   <= idx_reg;
            best_rem_reg   <= rd_rem;
            best_arr_reg   <= rd_arr;
            best_burst_reg <= rd_burst;
        end
        if (cmd.update)
        begin
            turn_reg <= time_next - best_arr_reg;
        end
        if (cmd.emit)
        begin
            out_reg <= out_next;
        end
    end

endmodule
